FILE: hw/rtl/pls_pkg.sv
// Shared types and constants for the positional list store.
package pls_pkg;

  // Default store depth and fixed field widths
  localparam int DEPTH_DEF = 16;
  localparam int REQ_W     = 2;
  localparam int POS_W     = 5;
  localparam int VAL_W     = 32;
  localparam int STAT_W    = 2;
  localparam int CNT_OUT_W = 5;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT  = 2'd0,
    REQ_DELETE  = 2'd1,
    REQ_MODIFY  = 2'd2,
    REQ_REVERSE = 2'd3
  } req_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;  // open a slot at idx, shift cells above it up
    logic del;  // close the slot at idx, shift cells above it down
    logic wr;   // overwrite the cell at idx
  } cell_cmd_t;

endpackage

FILE: hw/rtl/positional_list_store_top.sv
// Top level of the positional list store: control unit and chain of cells.
//
// Bounded ordered list of up to DEPTH signed 32-bit values. Each request
// (insert, delete, modify, reverse) completes when taken, so a new request
// may be issued every cycle; busy is never raised. The result item (status
// and the entry count after the request) appears on the out_ ports exactly
// one cycle after the request is taken, marked by out_valid for that single
// cycle, and must be captured then since it cannot be held off. Every cell
// shifts, loads or holds in parallel, and reverse only flips a direction
// bit, so no request ever holds the block busy.
module positional_list_store_top #(
  parameter int DEPTH = pls_pkg::DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [pls_pkg::REQ_W-1:0]            in_req_type,
  input  logic [pls_pkg::POS_W-1:0]            in_position,
  input  logic signed [pls_pkg::VAL_W-1:0]     in_new_value,
  output logic                                 out_valid,
  output logic [pls_pkg::STAT_W-1:0]           out_status,
  output logic [pls_pkg::CNT_OUT_W-1:0]        out_count
);

  localparam int IDX_W = $clog2(DEPTH);

  pls_pkg::cell_cmd_t         cmd;
  logic [IDX_W-1:0]           idx;
  logic                       accept;
  logic [pls_pkg::VAL_W-1:0]  cell_q [DEPTH];

  // Every request completes in the cycle it is taken
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  pls_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .req_type   (in_req_type),
    .position   (in_position),
    .cmd        (cmd),
    .idx        (idx),
    .out_valid  (out_valid),
    .out_status (out_status),
    .out_count  (out_count)
  );

  // Chain of cells; end cells feed back their own value at the open edge
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [pls_pkg::VAL_W-1:0] left_q;
    logic [pls_pkg::VAL_W-1:0] right_q;

    if (i == 0) begin : g_first
      assign left_q = cell_q[i];
    end else begin : g_mid_l
      assign left_q = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_q = cell_q[i];
    end else begin : g_mid_r
      assign right_q = cell_q[i+1];
    end

    pls_cell #(
      .IDX   (i),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .idx       (idx),
      .new_value (in_new_value),
      .left_q    (left_q),
      .right_q   (right_q),
      .q         (cell_q[i])
    );
  end

endmodule

FILE: hw/rtl/pls_cell.sv
// One storage cell of the list chain: load, shift from a neighbor, or hold.
module pls_cell #(
  parameter int IDX   = 0,
  parameter int IDX_W = 4
) (
  input  logic                        clk,
  input  pls_pkg::cell_cmd_t          cmd,
  input  logic [IDX_W-1:0]            idx,
  input  logic [pls_pkg::VAL_W-1:0]   new_value,
  input  logic [pls_pkg::VAL_W-1:0]   left_q,
  input  logic [pls_pkg::VAL_W-1:0]   right_q,
  output logic [pls_pkg::VAL_W-1:0]   q
);

  logic [pls_pkg::VAL_W-1:0] data_r;
  logic [pls_pkg::VAL_W-1:0] data_nxt;
  logic                      at_idx;
  logic                      above_idx;

  assign at_idx    = (idx == IDX_W'(IDX));
  assign above_idx = (idx <  IDX_W'(IDX));

  // Pick the next value: shift up, shift down, load, or hold
  always_comb begin
    data_nxt = data_r;
    if (cmd.ins) begin
      if (above_idx) begin
        data_nxt = left_q;
      end else if (at_idx) begin
        data_nxt = new_value;
      end
    end
    if (cmd.del && (above_idx || at_idx)) begin
      data_nxt = right_q;
    end
    if (cmd.wr && at_idx) begin
      data_nxt = new_value;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

FILE: hw/rtl/pls_ctrl.sv
// Request decode, length and direction tracking, and result register.
module pls_ctrl #(
  parameter int DEPTH = pls_pkg::DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  logic [pls_pkg::REQ_W-1:0]      req_type,
  input  logic [pls_pkg::POS_W-1:0]      position,
  output pls_pkg::cell_cmd_t             cmd,
  output logic [$clog2(DEPTH)-1:0]       idx,
  output logic                           out_valid,
  output logic [pls_pkg::STAT_W-1:0]     out_status,
  output logic [pls_pkg::CNT_OUT_W-1:0]  out_count
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > pls_pkg::POS_W) ? CNT_W : pls_pkg::POS_W;

  logic [CNT_W-1:0]      cnt_r;
  logic [CNT_W-1:0]      cnt_nxt;
  logic                  rev_r;
  logic                  rev_nxt;
  logic                  valid_r;
  pls_pkg::status_t      status_r;
  pls_pkg::status_t      status_nxt;
  pls_pkg::req_t         req;
  logic [CMP_W-1:0]      pos_x;
  logic [CMP_W-1:0]      cnt_x;
  logic [CMP_W-1:0]      idx_x;
  logic                  full;
  logic                  empty;

  assign req   = pls_pkg::req_t'(req_type);
  assign pos_x = CMP_W'(position);
  assign cnt_x = CMP_W'(cnt_r);
  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);

  // Map the logical position onto the physical cell; a reversed list
  // counts from the top of the occupied cells downward
  always_comb begin
    if (req == pls_pkg::REQ_INSERT) begin
      idx_x = rev_r ? (cnt_x - pos_x) : pos_x;
    end else begin
      idx_x = rev_r ? (cnt_x - pos_x - CMP_W'(1)) : pos_x;
    end
  end

  assign idx = idx_x[IDX_W-1:0];

  // Check the request, issue the cell command, update length and direction
  always_comb begin
    cmd        = '0;
    cnt_nxt    = cnt_r;
    rev_nxt    = rev_r;
    status_nxt = pls_pkg::ST_OK;
    case (req)
      pls_pkg::REQ_INSERT: begin
        if (full) begin
          status_nxt = pls_pkg::ST_FULL;
        end else if (pos_x > cnt_x) begin
          status_nxt = pls_pkg::ST_BADPOS;
        end else begin
          cmd.ins = accept;
          cnt_nxt = CNT_W'(cnt_r + 1'b1);
        end
      end
      pls_pkg::REQ_DELETE: begin
        if (empty) begin
          status_nxt = pls_pkg::ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          status_nxt = pls_pkg::ST_BADPOS;
        end else begin
          cmd.del = accept;
          cnt_nxt = CNT_W'(cnt_r - 1'b1);
        end
      end
      pls_pkg::REQ_MODIFY: begin
        if (empty) begin
          status_nxt = pls_pkg::ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          status_nxt = pls_pkg::ST_BADPOS;
        end else begin
          cmd.wr = accept;
        end
      end
      pls_pkg::REQ_REVERSE: begin
        rev_nxt = ~rev_r;
      end
      default: begin
        status_nxt = pls_pkg::ST_OK;
      end
    endcase
  end

  // Commit state and the result item on an accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      rev_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= accept;
      if (accept) begin
        cnt_r <= cnt_nxt;
        rev_r <= rev_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
    end
  end

  assign out_valid  = valid_r;
  assign out_status = status_r;
  assign out_count  = pls_pkg::CNT_OUT_W'(cnt_r);

endmodule

FILE: test/positional_list_store_top_tb.sv
// Self-checking testbench for the positional list store: random and directed requests.
`timescale 1ns / 1ps

module positional_list_store_top_tb;
  import pls_pkg::*;

  localparam int STORE_DEPTH = DEPTH_DEF;
  localparam int RANDOM_ITEMS = 700;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [VAL_W-1:0] VAL_MAX = 32'h7fff_ffff;

  // One request item as queued for the driver
  typedef struct {
    req_t             op;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    int               gap;
    bit               drain;
  } list_req_t;

  // One predicted result item
  typedef struct {
    status_t              status;
    logic [CNT_OUT_W-1:0] count;
  } list_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [REQ_W-1:0]          in_req_type = '0;
  logic [POS_W-1:0]          in_position = '0;
  logic signed [VAL_W-1:0]   in_new_value = '0;
  logic                      out_valid;
  logic [STAT_W-1:0]         out_status;
  logic [CNT_OUT_W-1:0]      out_count;

  list_req_t    req_q[$];
  list_result_t result_q[$];
  int           outstanding_q = 0;
  bit           all_sent = 1'b0;
  int           errors = 0;
  int           cycles = 0;

  // Predictor state: stored values and their count
  logic [VAL_W-1:0] list_vals[STORE_DEPTH];
  int               list_len = 0;

  // Generator view of the count, used to aim positions at the valid range
  int gen_len = 0;
  bit no_gaps = 1'b0;

  int     idle_left = 0;
  bit     gap_loaded = 1'b0;
  list_req_t next_req;

  positional_list_store_top #(.DEPTH(STORE_DEPTH)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_req_type  (in_req_type),
    .in_position  (in_position),
    .in_new_value (in_new_value),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_count    (out_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Apply one request to the predicted list and return its status
  function automatic status_t apply_request(req_t op, logic [POS_W-1:0] pos,
                                            logic [VAL_W-1:0] val);
    int i;
    logic [VAL_W-1:0] tmp;
    status_t st;
    st = ST_OK;
    case (op)
      REQ_INSERT: begin
        if (list_len >= STORE_DEPTH) begin
          st = ST_FULL;
        end else if (int'(pos) > list_len) begin
          st = ST_BADPOS;
        end else begin
          for (i = list_len; i > int'(pos); i--) list_vals[i] = list_vals[i-1];
          list_vals[pos] = val;
          list_len++;
        end
      end
      REQ_DELETE: begin
        if (list_len == 0) begin
          st = ST_EMPTY;
        end else if (int'(pos) >= list_len) begin
          st = ST_BADPOS;
        end else begin
          for (i = int'(pos); i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
          list_len--;
        end
      end
      REQ_MODIFY: begin
        if (list_len == 0) begin
          st = ST_EMPTY;
        end else if (int'(pos) >= list_len) begin
          st = ST_BADPOS;
        end else begin
          list_vals[pos] = val;
        end
      end
      default: begin
        for (i = 0; i < list_len / 2; i++) begin
          tmp = list_vals[i];
          list_vals[i] = list_vals[list_len-1-i];
          list_vals[list_len-1-i] = tmp;
        end
      end
    endcase
    return st;
  endfunction

  // Queue one item with a random lead-in gap and track the expected count
  task automatic add_item(req_t op, int pos, logic [VAL_W-1:0] val);
    list_req_t r;
    r.op = op;
    r.pos = pos[POS_W-1:0];
    r.val = val;
    r.gap = no_gaps ? 0 : $urandom_range(0, 5);
    r.drain = 1'b0;
    req_q.push_back(r);
    if (op == REQ_INSERT && gen_len < STORE_DEPTH && pos <= gen_len) gen_len++;
    if (op == REQ_DELETE && gen_len > 0 && pos < gen_len) gen_len--;
  endtask

  // Draw a value, with the extremes now and then
  function automatic logic [VAL_W-1:0] pick_value();
    logic [VAL_W-1:0] v;
    case ($urandom_range(0, 19))
      0: v = VAL_MIN;
      1: v = VAL_MAX;
      2: v = '0;
      3: v = '1;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Drive items from the queue, honoring gaps and drain pauses
  always @(posedge clk) begin : drive_blk
    bit fired;
    fired = start && !busy;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !fired) begin
      // hold the item until the block takes it
    end else if (req_q.size() == 0) begin
      start <= 1'b0;
      all_sent <= 1'b1;
    end else begin
      if (!gap_loaded) begin
        idle_left = req_q[0].gap;
        gap_loaded = 1'b1;
      end
      if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (req_q[0].drain && (fired || outstanding_q != 0)) begin
        start <= 1'b0;
      end else begin
        next_req = req_q.pop_front();
        in_req_type <= next_req.op;
        in_position <= next_req.pos;
        in_new_value <= next_req.val;
        start <= 1'b1;
        gap_loaded = 1'b0;
      end
    end
  end

  // Check each result against the oldest prediction, then predict accepted items
  always @(posedge clk) begin : check_blk
    list_result_t want;
    list_result_t pred;
    if (rst_n && out_valid) begin
      if (result_q.size() == 0) begin
        $error("unexpected result: status %0d count %0d", out_status, out_count);
        errors++;
      end else begin
        want = result_q.pop_front();
        if (out_status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, out_status);
          errors++;
        end
        if (out_count !== want.count) begin
          $error("count mismatch: expected %0d, actual %0d", want.count, out_count);
          errors++;
        end
      end
    end
    if (rst_n && start && !busy) begin
      pred.status = apply_request(req_t'(in_req_type), in_position, in_new_value);
      pred.count = list_len[CNT_OUT_W-1:0];
      result_q.push_back(pred);
    end
    outstanding_q <= result_q.size();
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : main_blk
    int i;
    int roll;
    int pos;
    bit fill_phase;
    req_t op;

    // Empty-store cases and insert beyond the count
    add_item(REQ_REVERSE, 0, '1);
    add_item(REQ_DELETE, 0, '0);
    add_item(REQ_MODIFY, 0, VAL_MAX);
    add_item(REQ_INSERT, 1, 32'h1234_5678);
    // Build a short list with front, back and middle inserts, then modify, reverse and shrink it
    add_item(REQ_INSERT, 0, VAL_MIN);
    add_item(REQ_INSERT, 1, VAL_MAX);
    add_item(REQ_INSERT, 0, '1);
    add_item(REQ_INSERT, 1, '0);
    add_item(REQ_MODIFY, 3, 32'h0000_0005);
    add_item(REQ_MODIFY, 4, 32'hdead_beef);
    add_item(REQ_DELETE, 4, '0);
    add_item(REQ_REVERSE, 31, '0);
    add_item(REQ_DELETE, 3, '0);
    add_item(REQ_DELETE, 0, '0);
    add_item(REQ_DELETE, 1, '0);
    add_item(REQ_REVERSE, 0, '0);
    // Fill to full, then full store takes precedence over a bad position
    while (gen_len < STORE_DEPTH) add_item(REQ_INSERT, $urandom_range(0, gen_len), pick_value());
    add_item(REQ_INSERT, 0, VAL_MIN);
    add_item(REQ_INSERT, 31, VAL_MAX);
    add_item(REQ_MODIFY, 31, '0);
    add_item(REQ_DELETE, STORE_DEPTH, '0);
    add_item(REQ_REVERSE, 0, '0);
    add_item(REQ_DELETE, STORE_DEPTH - 1, '0);
    req_q[req_q.size()-1].drain = 1'b1;

    // Random part: alternate fill-heavy and drain-heavy phases
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      fill_phase = ((i / 60) % 2) == 0;
      no_gaps = ((i / 50) % 3) == 2;
      roll = $urandom_range(0, 99);
      if (roll < 10) op = REQ_REVERSE;
      else if (roll < 30) op = REQ_MODIFY;
      else if (roll < (fill_phase ? 85 : 45)) op = REQ_INSERT;
      else op = REQ_DELETE;
      if ($urandom_range(0, 99) < 80) begin
        if (op == REQ_INSERT) pos = $urandom_range(0, gen_len);
        else pos = (gen_len > 0) ? $urandom_range(0, gen_len - 1) : 0;
      end else begin
        pos = $urandom_range(0, 31);
      end
      add_item(op, pos, pick_value());
      if (i == RANDOM_ITEMS / 2 || $urandom_range(0, 99) < 2) req_q[req_q.size()-1].drain = 1'b1;
    end

    // Hold reset, then release and wait for the run to drain
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    while (!(all_sent && outstanding_q == 0)) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
